FILE: hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion macros used by the grid addresser top file.
// Defining NO_ASSERTIONS turns every check into an empty statement.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// check on every clock edge outside of reset
`define SGCA_ASSERT(lbl, ck, rn, prop, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rn) prop) \
    else $error(msg);

// check on every clock edge, reset included
`define SGCA_ASSERT_ALWAYS(lbl, ck, prop, msg) \
  lbl: assert property (@(posedge ck) prop) else $error(msg);

`else

`define SGCA_ASSERT(lbl, ck, rn, prop, msg)
`define SGCA_ASSERT_ALWAYS(lbl, ck, prop, msg)

`endif

`endif

FILE: hdl/sgca_pkg.sv
// ----------------------------------------------------------------------------
// sgca_pkg
// Widths, codes and shared types of the structured grid cell addresser.
// ----------------------------------------------------------------------------
package sgca_pkg;

  // field widths
  localparam int CNT_W     = 10;
  localparam int ID_W      = 30;
  localparam int PLANE_W   = 2 * CNT_W + 1;
  localparam int CORNER_W  = 3;
  localparam int REG_IDX_W = 2;

  // one restoring division step per cell, two divisions in the row
  localparam int DIV_STEPS = CNT_W;
  localparam int NUM_CELLS = 2 * DIV_STEPS;

  // request codes
  localparam logic FUNC_CELL = 1'b0;
  localparam logic FUNC_NODE = 1'b1;

  // register indexes
  localparam logic [REG_IDX_W-1:0] REG_CELLS_X = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_CELLS_Y = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_CELLS_Z = 2'd2;

  localparam logic [CORNER_W-1:0] CORNER_LAST = 3'd7;

  // grid sizes and values derived from them
  typedef struct packed {
    logic [CNT_W-1:0]   cx;
    logic [CNT_W-1:0]   cy;
    logic [CNT_W-1:0]   cz;
    logic [CNT_W:0]     nz;
    logic [PLANE_W-1:0] plane;
    logic [PLANE_W-1:0] pnz;
  } grid_cfg_t;

  // one input item
  typedef struct packed {
    logic             func;
    logic [CNT_W-1:0] cell_i;
    logic [CNT_W-1:0] cell_j;
    logic [CNT_W-1:0] cell_k;
    logic [ID_W-1:0]  query_node;
  } in_item_t;

  // one result item
  typedef struct packed {
    logic                ok;
    logic [CORNER_W-1:0] corner;
    logic [ID_W-1:0]     corner_node;
    logic [ID_W-1:0]     element_number;
    logic [CNT_W-1:0]    node_i;
    logic [CNT_W-1:0]    node_j;
    logic [CNT_W-1:0]    node_k;
    logic                last;
  } out_item_t;

  // token moving along the cell row
  // cell request: rem = base node id, dvs = element id
  // node request: rem = partial remainder, dvs = shifted divisor
  typedef struct packed {
    logic             func;
    logic             ok;
    logic [ID_W-1:0]  rem;
    logic [ID_W-1:0]  dvs;
    logic [CNT_W-1:0] quo;
    logic [CNT_W-1:0] ni;
  } tok_t;

endpackage

FILE: hdl/sgca_in_if.sv
// ----------------------------------------------------------------------------
// sgca_in_if
// Request channel: valid/ready handshake with the request fields.
// ----------------------------------------------------------------------------
interface sgca_in_if;
  logic                         valid;
  logic                         ready;
  logic                         func;
  logic [sgca_pkg::CNT_W-1:0]   cell_i;
  logic [sgca_pkg::CNT_W-1:0]   cell_j;
  logic [sgca_pkg::CNT_W-1:0]   cell_k;
  logic [sgca_pkg::ID_W-1:0]    query_node;

  modport source (output valid, func, cell_i, cell_j, cell_k, query_node, input ready);
  modport sink (input valid, func, cell_i, cell_j, cell_k, query_node, output ready);
endinterface

FILE: hdl/sgca_out_if.sv
// ----------------------------------------------------------------------------
// sgca_out_if
// Result channel: valid/ready handshake with the result fields.
// ----------------------------------------------------------------------------
interface sgca_out_if;
  logic                          valid;
  logic                          ready;
  logic                          ok;
  logic [sgca_pkg::CORNER_W-1:0] corner;
  logic [sgca_pkg::ID_W-1:0]     corner_node;
  logic [sgca_pkg::ID_W-1:0]     element_number;
  logic [sgca_pkg::CNT_W-1:0]    node_i;
  logic [sgca_pkg::CNT_W-1:0]    node_j;
  logic [sgca_pkg::CNT_W-1:0]    node_k;
  logic                          last;

  modport source (output valid, ok, corner, corner_node, element_number,
                  node_i, node_j, node_k, last, input ready);
  modport sink (input valid, ok, corner, corner_node, element_number,
                node_i, node_j, node_k, last, output ready);
endinterface

FILE: hdl/sgca_cfg_if.sv
// ----------------------------------------------------------------------------
// sgca_cfg_if
// Register write channel: valid/ready handshake, register index and data.
// ----------------------------------------------------------------------------
interface sgca_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [sgca_pkg::REG_IDX_W-1:0] index;
  logic [sgca_pkg::CNT_W-1:0]     data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

FILE: hdl/structured_grid_cell_addresser.sv
// ----------------------------------------------------------------------------
// structured_grid_cell_addresser
// Row-major addressing of a structured hexahedral grid: cell to corner node
// ids and element id, or node id to its three indices.
// ----------------------------------------------------------------------------
// A cell request (func 0) gives eight results when in range, corners in the
// usual hexahedron order with last on corner 7, and one result with ok low
// otherwise; a node request (func 1) gives one result. Requests go through two
// product stages and a row of twenty division cells, one quotient bit per cell,
// then the result register. A new request is taken every cycle while the result
// port keeps up, so the rate is set by the result port alone. The derived grid
// sizes are registered: the plane size from the counts, then plane plus one
// j-row from the plane size.
`include "assert_macros.svh"

module structured_grid_cell_addresser #(
  parameter int unsigned MAX_DIV = 1023
) (
  input  logic           clk,
  input  logic           rst_n,
  sgca_in_if.sink        in_ch,
  sgca_out_if.source     out_ch,
  sgca_cfg_if.sink       cfg_ch
);

  localparam int DS = sgca_pkg::DIV_STEPS;
  localparam int NC = sgca_pkg::NUM_CELLS;

  logic [sgca_pkg::CNT_W-1:0]   cx_r, cy_r, cz_r;
  logic [sgca_pkg::PLANE_W-1:0] plane_r, pnz_r;
  logic [sgca_pkg::CNT_W-1:0]   cfg_val;
  logic [sgca_pkg::CNT_W:0]     ny, nz;
  sgca_pkg::grid_cfg_t          grid;
  sgca_pkg::in_item_t           in_item;
  sgca_pkg::out_item_t          out_item;

  logic                         adv;
  logic                         take;
  logic                         front_vld;
  sgca_pkg::tok_t               front_tok;
  sgca_pkg::tok_t               mid_tok;
  logic                         src_vld  [NC];
  sgca_pkg::tok_t               src_tok  [NC];
  logic                         cell_vld [NC];
  sgca_pkg::tok_t               cell_tok [NC];
  logic                         tail_vld;

  // register writes, counts saturate at MAX_DIV
  assign cfg_ch.ready = 1'b1;
  assign cfg_val = (32'(cfg_ch.data) > MAX_DIV) ? sgca_pkg::CNT_W'(MAX_DIV) : cfg_ch.data;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cx_r <= sgca_pkg::CNT_W'(1);
      cy_r <= sgca_pkg::CNT_W'(1);
      cz_r <= sgca_pkg::CNT_W'(1);
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        sgca_pkg::REG_CELLS_X: cx_r <= cfg_val;
        sgca_pkg::REG_CELLS_Y: cy_r <= cfg_val;
        sgca_pkg::REG_CELLS_Z: cz_r <= cfg_val;
        default: ;
      endcase
    end
  end

  // derived sizes: nodes per i-plane, and plane plus one j-row
  assign ny = {1'b0, cy_r} + (sgca_pkg::CNT_W + 1)'(1);
  assign nz = {1'b0, cz_r} + (sgca_pkg::CNT_W + 1)'(1);

  always_ff @(posedge clk) begin
    plane_r <= sgca_pkg::PLANE_W'(ny) * sgca_pkg::PLANE_W'(nz);
    pnz_r   <= plane_r + sgca_pkg::PLANE_W'(nz);
  end

  always_comb begin
    grid.cx    = cx_r;
    grid.cy    = cy_r;
    grid.cz    = cz_r;
    grid.nz    = nz;
    grid.plane = plane_r;
    grid.pnz   = pnz_r;
  end

  // request item
  always_comb begin
    in_item.func       = in_ch.func;
    in_item.cell_i     = in_ch.cell_i;
    in_item.cell_j     = in_ch.cell_j;
    in_item.cell_k     = in_ch.cell_k;
    in_item.query_node = in_ch.query_node;
  end

  // the whole row moves unless a token waits on a busy result register
  assign tail_vld    = cell_vld[NC-1];
  assign adv         = !tail_vld || take;
  assign in_ch.ready = adv;

  sgca_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .adv     (adv),
    .in_vld  (in_ch.valid),
    .in_item (in_item),
    .cfg     (grid),
    .out_vld (front_vld),
    .out_tok (front_tok)
  );

  // between the two divisions: keep i, check it, load the z divisor
  always_comb begin
    mid_tok = cell_tok[DS-1];
    if (cell_tok[DS-1].func == sgca_pkg::FUNC_NODE) begin
      mid_tok.ni  = cell_tok[DS-1].quo;
      mid_tok.quo = '0;
      mid_tok.ok  = cell_tok[DS-1].ok && (cell_tok[DS-1].quo <= cx_r);
      mid_tok.dvs = sgca_pkg::ID_W'({nz, {(DS - 1){1'b0}}});
    end
  end

  // row of division cells
  for (genvar g = 0; g < NC; g++) begin : g_cell
    if (g == 0) begin : g_head
      assign src_vld[g] = front_vld;
      assign src_tok[g] = front_tok;
    end else if (g == DS) begin : g_mid
      assign src_vld[g] = cell_vld[g-1];
      assign src_tok[g] = mid_tok;
    end else begin : g_link
      assign src_vld[g] = cell_vld[g-1];
      assign src_tok[g] = cell_tok[g-1];
    end

    sgca_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .adv     (adv),
      .in_vld  (src_vld[g]),
      .in_tok  (src_tok[g]),
      .out_vld (cell_vld[g]),
      .out_tok (cell_tok[g])
    );
  end

  sgca_emit u_emit (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_vld    (tail_vld),
    .in_tok    (cell_tok[NC-1]),
    .cfg       (grid),
    .take      (take),
    .out_ready (out_ch.ready),
    .out_vld   (out_ch.valid),
    .out_item  (out_item)
  );

  // result item
  assign out_ch.ok             = out_item.ok;
  assign out_ch.corner         = out_item.corner;
  assign out_ch.corner_node    = out_item.corner_node;
  assign out_ch.element_number = out_item.element_number;
  assign out_ch.node_i         = out_item.node_i;
  assign out_ch.node_j         = out_item.node_j;
  assign out_ch.node_k         = out_item.node_k;
  assign out_ch.last           = out_item.last;

  // only corners of an in-range cell are not last, and corner 7 is always last
  `SGCA_ASSERT(a_not_last_is_corner, clk, rst_n, out_ch.valid && !out_ch.last |-> out_ch.ok && out_ch.corner != sgca_pkg::CORNER_LAST, "non-last result is not an inner corner")

  // a taken inner corner is followed by the next corner of the same cell
  `SGCA_ASSERT(a_corner_steps, clk, rst_n, out_ch.valid && out_ch.ready && !out_ch.last |=> out_ch.valid && out_ch.corner == 3'($past(out_ch.corner) + 3'd1) && $stable(out_ch.element_number), "corner sequence broken")

  // single results carry no node or element id
  `SGCA_ASSERT(a_single_no_ids, clk, rst_n, out_ch.valid && out_ch.last && out_ch.corner != sgca_pkg::CORNER_LAST |-> out_ch.corner_node == '0 && out_ch.element_number == '0, "single result carries ids")

endmodule

FILE: hdl/sgca_front.sv
// ----------------------------------------------------------------------------
// sgca_front
// Two-stage entry of the row: range checks, then the row-major products of a
// cell request's base node and element ids, or a node request's divider setup.
// ----------------------------------------------------------------------------
module sgca_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                adv,
  input  logic                in_vld,
  input  sgca_pkg::in_item_t  in_item,
  input  sgca_pkg::grid_cfg_t cfg,
  output logic                out_vld,
  output sgca_pkg::tok_t      out_tok
);

  localparam int E_W = 2 * sgca_pkg::CNT_W;

  typedef struct packed {
    logic                       func;
    logic                       ok;
    logic [E_W-1:0]             e1;
    logic [E_W-1:0]             n1;
    logic [sgca_pkg::CNT_W-1:0] k;
    logic [sgca_pkg::ID_W-1:0]  id;
  } stage1_t;

  stage1_t                      s1_r, s1_nxt;
  logic                         s1_vld_r;
  logic                         s2_vld_r;
  sgca_pkg::tok_t               s2_r, s2_nxt;
  logic [sgca_pkg::CNT_W:0]     ny;
  logic                         cell_ok;
  logic                         node_ok;
  logic [sgca_pkg::ID_W-1:0]    elem;
  logic [sgca_pkg::ID_W-1:0]    node0;

  // stage 1: bounds and first products i*cy+j, i*(cy+1)+j
  always_comb begin
    ny      = {1'b0, cfg.cy} + (sgca_pkg::CNT_W + 1)'(1);
    cell_ok = (in_item.cell_i < cfg.cx) && (in_item.cell_j < cfg.cy) &&
              (in_item.cell_k < cfg.cz);
    // quotient of the first division must fit in CNT_W bits
    node_ok = (sgca_pkg::ID_W + 1)'(in_item.query_node) <
              {cfg.plane, {sgca_pkg::CNT_W{1'b0}}};
    s1_nxt.func = in_item.func;
    s1_nxt.ok   = (in_item.func == sgca_pkg::FUNC_NODE) ? node_ok : cell_ok;
    s1_nxt.e1   = E_W'(in_item.cell_i) * E_W'(cfg.cy) + E_W'(in_item.cell_j);
    s1_nxt.n1   = E_W'(in_item.cell_i) * E_W'(ny) + E_W'(in_item.cell_j);
    s1_nxt.k    = in_item.cell_k;
    s1_nxt.id   = in_item.query_node;
  end

  // stage 2: second products, or divider setup for a node request
  always_comb begin
    elem  = sgca_pkg::ID_W'(s1_r.e1) * sgca_pkg::ID_W'(cfg.cz) +
            sgca_pkg::ID_W'(s1_r.k);
    node0 = sgca_pkg::ID_W'(s1_r.n1) * sgca_pkg::ID_W'(cfg.nz) +
            sgca_pkg::ID_W'(s1_r.k);
    s2_nxt.func = s1_r.func;
    s2_nxt.ok   = s1_r.ok;
    s2_nxt.quo  = '0;
    s2_nxt.ni   = '0;
    if (s1_r.func == sgca_pkg::FUNC_NODE) begin
      s2_nxt.rem = s1_r.id;
      s2_nxt.dvs = sgca_pkg::ID_W'({cfg.plane, {(sgca_pkg::DIV_STEPS - 1){1'b0}}});
    end else begin
      s2_nxt.rem = node0;
      s2_nxt.dvs = elem;
    end
  end

  // stage valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
    end else if (adv) begin
      s1_vld_r <= in_vld;
      s2_vld_r <= s1_vld_r;
    end
  end

  // stage payload
  always_ff @(posedge clk) begin
    if (adv) begin
      s1_r <= s1_nxt;
      s2_r <= s2_nxt;
    end
  end

  assign out_vld = s2_vld_r;
  assign out_tok = s2_r;

endmodule

FILE: hdl/sgca_cell.sv
// ----------------------------------------------------------------------------
// sgca_cell
// One cell of the row: a restoring division step on node requests, a plain
// pass for cell requests.
// ----------------------------------------------------------------------------
module sgca_cell (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           adv,
  input  logic           in_vld,
  input  sgca_pkg::tok_t in_tok,
  output logic           out_vld,
  output sgca_pkg::tok_t out_tok
);

  logic           vld_r;
  sgca_pkg::tok_t tok_r, tok_nxt;

  // subtract the shifted divisor when it fits, shift in the quotient bit
  always_comb begin
    tok_nxt = in_tok;
    if (in_tok.func == sgca_pkg::FUNC_NODE) begin
      if (in_tok.rem >= in_tok.dvs) begin
        tok_nxt.rem = in_tok.rem - in_tok.dvs;
        tok_nxt.quo = {in_tok.quo[sgca_pkg::CNT_W-2:0], 1'b1};
      end else begin
        tok_nxt.quo = {in_tok.quo[sgca_pkg::CNT_W-2:0], 1'b0};
      end
      tok_nxt.dvs = in_tok.dvs >> 1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (adv) begin
      vld_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      tok_r <= tok_nxt;
    end
  end

  assign out_vld = vld_r;
  assign out_tok = tok_r;

endmodule

FILE: hdl/sgca_emit.sv
// ----------------------------------------------------------------------------
// sgca_emit
// Result register at the end of the row. Expands an in-range cell request
// into its eight corners, one per accepted result.
// ----------------------------------------------------------------------------
module sgca_emit (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_vld,
  input  sgca_pkg::tok_t       in_tok,
  input  sgca_pkg::grid_cfg_t  cfg,
  output logic                 take,
  input  logic                 out_ready,
  output logic                 out_vld,
  output sgca_pkg::out_item_t  out_item
);

  logic                            out_vld_r;
  sgca_pkg::out_item_t             item_r;
  sgca_pkg::out_item_t             load_item;
  logic [sgca_pkg::ID_W-1:0]       base_r;
  logic [sgca_pkg::CORNER_W-1:0]   cnr_nxt;
  logic [sgca_pkg::ID_W-1:0]       off;
  logic [sgca_pkg::ID_W-1:0]       step_node;
  logic                            load;
  logic                            step;

  assign take = !out_vld_r || (out_ready && item_r.last);
  assign load = in_vld && take;
  assign step = out_vld_r && out_ready && !item_r.last;

  // first result of a token
  always_comb begin
    load_item      = '0;
    load_item.last = 1'b1;
    if (in_tok.ok) begin
      load_item.ok = 1'b1;
      if (in_tok.func == sgca_pkg::FUNC_CELL) begin
        load_item.corner_node    = in_tok.rem;
        load_item.element_number = in_tok.dvs;
        load_item.last           = 1'b0;
      end else begin
        load_item.node_i = in_tok.ni;
        load_item.node_j = in_tok.quo;
        load_item.node_k = in_tok.rem[sgca_pkg::CNT_W-1:0];
      end
    end
  end

  // next corner: base + offset for (di, dj) + dk
  always_comb begin
    cnr_nxt = item_r.corner + sgca_pkg::CORNER_W'(1);
    case (cnr_nxt[1:0])
      2'd1:    off = sgca_pkg::ID_W'(cfg.plane);
      2'd2:    off = sgca_pkg::ID_W'(cfg.pnz);
      2'd3:    off = sgca_pkg::ID_W'(cfg.nz);
      default: off = '0;
    endcase
    step_node = base_r + off + sgca_pkg::ID_W'(cnr_nxt[2]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (load) begin
      out_vld_r <= 1'b1;
    end else if (out_ready && item_r.last) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      item_r <= load_item;
      base_r <= in_tok.rem;
    end else if (step) begin
      item_r.corner      <= cnr_nxt;
      item_r.corner_node <= step_node;
      item_r.last        <= (cnr_nxt == sgca_pkg::CORNER_LAST);
    end
  end

  assign out_vld  = out_vld_r;
  assign out_item = item_r;

endmodule
